### design/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SUP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication whose consequent is due in the next cycle.
`define SUP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sup_pkg.sv
// Package: operation and status codes, default capacity and cell control struct.
package sup_pkg;

    localparam int SUP_CAPACITY = 64;
    localparam int ADDR_W       = 32;
    localparam int RANK_W       = 6;
    localparam int COUNT_W      = 7;
    localparam int OPCODE_W     = 2;
    localparam int STATUS_W     = 2;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POP    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_GET    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic load;
        logic ins_en;
        logic pop_en;
    } sup_ctrl_t;

endpackage

### design/sup_cell.sv
// One storage cell of the sorted chain: an entry, its compare flags and shift logic.
module sup_cell
    import sup_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
)
(
    input  logic              clk,
    input  sup_ctrl_t         ctrl,
    input  logic [ADDR_W-1:0] address_in,
    input  logic [RANK_W-1:0] rank_in,
    input  logic [CNT_W-1:0]  count_in,
    input  logic [ADDR_W-1:0] commit_addr,
    input  logic [ADDR_W-1:0] prev_entry,
    input  logic              prev_lt,
    input  logic [ADDR_W-1:0] next_entry,
    output logic [ADDR_W-1:0] entry,
    output logic              lt,
    output logic              hit,
    output logic [ADDR_W-1:0] rd_data
);

    localparam int  CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;
    localparam logic FIRST = (INDEX == 0);

    logic [ADDR_W-1:0] entry_reg;
    logic [ADDR_W-1:0] entry_next;
    logic              lt_reg;
    logic              hit_reg;
    logic              sel_reg;
    logic              occupied;

    assign occupied = CNT_W'(INDEX) < count_in;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en)
        begin
            if (lt_reg)
                entry_next = entry_reg;
            else if (FIRST || prev_lt)
                entry_next = commit_addr;
            else
                entry_next = prev_entry;
        end
        else if (ctrl.pop_en)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ctrl.load)
        begin
            lt_reg  <= occupied && (entry_reg < address_in);
            hit_reg <= occupied && (entry_reg == address_in);
            sel_reg <= occupied && (CMP_W'(rank_in) == CMP_W'(INDEX));
        end
    end

    assign entry   = entry_reg;
    assign lt      = lt_reg;
    assign hit     = hit_reg;
    assign rd_data = sel_reg ? entry_reg : '0;

endmodule

### design/sorted_unique_pointer_queue.sv
// Top level: sorted unique address queue built as a chain of storage cells.
//
// Input channel in_valid/in_ready carries opcode, address and rank; output
// channel out_valid/out_ready carries status, value and count, one result
// item for every input item, in order.
// Each item is handled in two steps: on acceptance every cell compares its entry
// with the address and rank; then, in the update state, the cells shift in place
// (insert moves the tail up one cell, pop moves everything down one cell)
// and the result is written to the output register. Only one item is in
// flight: in_ready stays low until the update of the current item is done.
// The output register lets the next item be accepted while a result waits.
// If the receiver stalls with a result still held, the update cycle waits
// and in_ready stays low until the output register frees.
// Reset empties the store (count zero) and clears both channels; the cells
// need no clearing, as only cells below the count are ever looked at.
module sorted_unique_pointer_queue
    import sup_pkg::*;
#(
    parameter int CAPACITY = SUP_CAPACITY
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [ADDR_W-1:0]   address,
    input  logic [RANK_W-1:0]   rank,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [ADDR_W-1:0]   value,
    output logic [COUNT_W-1:0]  count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [OPCODE_W-1:0] op_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                rank_ok_reg;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0]   value_reg, value_next;

    logic                accept;
    logic                fire;
    logic                do_ins;
    logic                do_pop;
    logic                dup;
    logic [ADDR_W-1:0]   rd_any;
    sup_ctrl_t           ctrl;

    logic [ADDR_W-1:0]   entry_w [CAPACITY];
    logic                lt_w    [CAPACITY];
    logic                hit_w   [CAPACITY];
    logic [ADDR_W-1:0]   rd_w    [CAPACITY];

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign fire     = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        dup    = 1'b0;
        rd_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            dup    = dup | hit_w[i];
            rd_any = rd_any | rd_w[i];
        end
    end

    always_comb
    begin
        status_next = ST_EMPTY;
        value_next  = '0;
        do_ins      = 1'b0;
        do_pop      = 1'b0;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (addr_reg == '0)
                    status_next = ST_EMPTY;
                else if (dup)
                    status_next = ST_DUP;
                else if (count_reg == CNT_W'(CAPACITY))
                    status_next = ST_FULL;
                else
                begin
                    status_next = ST_OK;
                    do_ins      = 1'b1;
                end
            end
            OP_POP:
            begin
                if (count_reg != '0)
                begin
                    status_next = ST_OK;
                    value_next  = entry_w[0];
                    do_pop      = 1'b1;
                end
            end
            OP_GET:
            begin
                if (rank_ok_reg)
                begin
                    status_next = ST_OK;
                    value_next  = rd_any;
                end
            end
            default:
            begin
                status_next = ST_EMPTY;
            end
        endcase
    end

    assign ctrl.load   = accept;
    assign ctrl.ins_en = fire && do_ins;
    assign ctrl.pop_en = fire && do_pop;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    if (do_ins)
                        count_next = count_reg + CNT_W'(1);
                    else if (do_pop)
                        count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= opcode;
            addr_reg    <= address;
            rank_ok_reg <= CMP_W'(rank) < CMP_W'(count_reg);
        end
        if (fire)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ADDR_W-1:0] prev_entry;
        logic              prev_lt;
        logic [ADDR_W-1:0] next_entry;

        if (i == 0)
        begin : g_first
            assign prev_entry = addr_reg;
            assign prev_lt    = 1'b0;
        end
        else
        begin : g_mid
            assign prev_entry = entry_w[i-1];
            assign prev_lt    = lt_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_entry = entry_w[i];
        end
        else
        begin : g_inner
            assign next_entry = entry_w[i+1];
        end

        sup_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .address_in  (address),
            .rank_in     (rank),
            .count_in    (count_reg),
            .commit_addr (addr_reg),
            .prev_entry  (prev_entry),
            .prev_lt     (prev_lt),
            .next_entry  (next_entry),
            .entry       (entry_w[i]),
            .lt          (lt_w[i]),
            .hit         (hit_w[i]),
            .rd_data     (rd_w[i])
        );
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;
    assign count     = COUNT_W'(count_reg);

endmodule

### design/sup_checker.sv
// Port-level checker for the sorted unique address queue, bound to the top level.
`include "assert_macros.svh"

module sup_checker
    import sup_pkg::*;
#(
    parameter int CAPACITY = SUP_CAPACITY
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [ADDR_W-1:0]   value,
    input logic [COUNT_W-1:0]  count
);

    `SUP_ASSERT(a_err_value_zero, out_valid && (status != ST_OK) |-> (value == '0), "nonzero value with error status")
    `SUP_ASSERT(a_full_count, out_valid && (status == ST_FULL) |-> (count == COUNT_W'(CAPACITY)), "full status below capacity")
    `SUP_ASSERT(a_count_bound, out_valid && (CAPACITY <= 127) |-> (int'(count) <= CAPACITY), "count above capacity")
    `SUP_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second item taken during update")
    `SUP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value) && $stable(status), "result dropped while stalled")

endmodule

bind sorted_unique_pointer_queue sup_checker #(.CAPACITY(CAPACITY)) u_sup_checker (.*);
